/* hdl/abbe_pkg.sv */
// shared constants, types and command codes of the alpha blend blit engine
// no dependencies; every other file of the block uses this package

package abbe_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int X_W         = $clog2(MAX_WIDTH);
   localparam int Y_W         = $clog2(MAX_HEIGHT);
   localparam int SIZE_W      = 7;
   localparam int POS_W       = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 32;

   localparam logic [SIZE_W-1:0] MAX_W_SZ   = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SZ   = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] CFG_RESET  = 7'd64;
   localparam logic [7:0]        PIX_FULL   = 8'd255;

   typedef enum logic [1:0] {
      CMD_DEST_WR = 2'd0,
      CMD_SRC_WR  = 2'd1,
      CMD_DEST_RD = 2'd2,
      CMD_BLIT    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEST_WIDTH  = 2'd0,
      CSR_DEST_HEIGHT = 2'd1,
      CSR_SRC_WIDTH   = 2'd2,
      CSR_SRC_HEIGHT  = 2'd3
   } csr_index_type;

   // request payload, fields declared from the highest bits down, so pos_x sits in the lowest bits
   typedef struct packed {
      logic [5:0]        pad;
      logic [7:0]        pixel_alpha;
      logic [7:0]        blue;
      logic [7:0]        green;
      logic [7:0]        red;
      logic [7:0]        blend_alpha;
      logic [SIZE_W-1:0] span_h;
      logic [SIZE_W-1:0] span_w;
      logic [POS_W-1:0]  src_y;
      logic [POS_W-1:0]  src_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_x;
   } req_data_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic clamp;
      logic addr;
      logic mem_access;
      logic blit_rd;
      logic blit_alpha;
      logic blit_mix;
      logic blit_wr;
      logic load_rsp;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_blit;
      logic span_zero;
      logic last_pixel;
   } stat_type;

endpackage

/* hdl/abbe_ctrl.sv */
// controller state machine of the alpha blend blit engine
// sequences request handling and the per-pixel blit loop; uses abbe_pkg

module abbe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  abbe_pkg::stat_type stat,
   output abbe_pkg::ctl_type  ctl
);
   import abbe_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CLAMP  = 9'b000000010,
      ST_ADDR   = 9'b000000100,
      ST_ACCESS = 9'b000001000,
      ST_RD     = 9'b000010000,
      ST_ALPHA  = 9'b000100000,
      ST_MIX    = 9'b001000000,
      ST_WR     = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.latch_req = 1'b1;
               state_in      = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            ctl.clamp = 1'b1;
            state_in  = ST_ADDR;
         end
         ST_ADDR: begin
            ctl.addr = 1'b1;
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            ctl.mem_access = 1'b1;
            if (stat.is_blit && !stat.span_zero) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            ctl.blit_rd = 1'b1;
            state_in    = ST_ALPHA;
         end
         ST_ALPHA: begin
            ctl.blit_alpha = 1'b1;
            state_in       = ST_MIX;
         end
         ST_MIX: begin
            ctl.blit_mix = 1'b1;
            state_in     = ST_WR;
         end
         ST_WR: begin
            ctl.blit_wr = 1'b1;
            state_in    = stat.last_pixel ? ST_DONE : ST_RD;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/abbe_datapath.sv */
// datapath of the alpha blend blit engine: size registers, clamping,
// address generation, both pixel stores and the blend arithmetic; uses abbe_pkg

module abbe_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  abbe_pkg::ctl_type                ctl,
   output abbe_pkg::stat_type               stat,
   input  abbe_pkg::cmd_type                req_cmd,
   input  abbe_pkg::req_data_type           req_data,
   input  logic                             csr_wr,
   input  logic [abbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [abbe_pkg::SIZE_W-1:0]      csr_data,
   output abbe_pkg::pixel_type              rsp_data,
   output logic                             rsp_is_read
);
   import abbe_pkg::*;

   // size register of 0 acts as 1, above the maximum saturates
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] s;
      s = r;
      if (r == '0) begin
         s = SIZE_W'(1);
      end else if (r > maxv) begin
         s = maxv;
      end
      return s;
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_pos(input logic [POS_W-1:0] v,
                                                   input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] c;
      c = v[SIZE_W-1:0];
      if (v[POS_W-1]) begin
         c = '0;
      end else if (v[POS_W-2:0] >= (POS_W-1)'(size)) begin
         c = size - SIZE_W'(1);
      end
      return c;
   endfunction

   // exact floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [15:0] mix_sum(input logic [7:0] s, input logic [7:0] d,
                                           input logic [7:0] a);
      logic [15:0] p;
      logic [15:0] q;
      p = 16'(s) * 16'(a);
      q = 16'(PIX_FULL - a) * 16'(d);
      return p + q;
   endfunction

   function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                              input logic [SIZE_W-1:0] b,
                                              input logic [SIZE_W-1:0] c);
      logic [SIZE_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   logic [SIZE_W-1:0] dest_width_ff, dest_width_in;
   logic [SIZE_W-1:0] dest_height_ff, dest_height_in;
   logic [SIZE_W-1:0] src_width_ff, src_width_in;
   logic [SIZE_W-1:0] src_height_ff, src_height_in;

   cmd_type           cmd_ff, cmd_in;
   req_data_type      req_ff, req_in;
   logic [SIZE_W-1:0] dw_e_ff, dw_e_in, dh_e_ff, dh_e_in;
   logic [SIZE_W-1:0] ow_e_ff, ow_e_in, oh_e_ff, oh_e_in;
   logic [X_W-1:0]    cx_ff, cx_in, cox_ff, cox_in;
   logic [Y_W-1:0]    cy_ff, cy_in, coy_ff, coy_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, srow_ff, srow_in;
   logic [SIZE_W-1:0] span_w_ff, span_w_in, span_h_ff, span_h_in;
   logic [X_W-1:0]    col_ff, col_in;
   logic [Y_W-1:0]    row_ff, row_in;
   logic [7:0]        a_ff, a_in, amax_ff, amax_in;
   logic [15:0]       sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   pixel_type         rsp_data_ff, rsp_data_in;
   logic              rsp_read_ff, rsp_read_in;
   pixel_type         dq_ff, sq_ff;

   pixel_type         dest_mem [STORE_DEPTH];
   pixel_type         src_mem [STORE_DEPTH];

   logic [SIZE_W-1:0] dwe, dhe, owe, ohe, x_lim, y_lim, w_sel;
   logic [SIZE_W+Y_W-1:0] prod_a, prod_s;
   logic [15:0]       a_prod;
   logic              last_col, last_row;
   logic              dest_we, dest_re, src_we, src_re;
   logic [ADDR_W-1:0] dest_addr, src_raddr;
   pixel_type         dest_wdata, blend_pix, req_pix;

   assign dwe = eff_size(dest_width_ff, MAX_W_SZ);
   assign dhe = eff_size(dest_height_ff, MAX_H_SZ);
   assign owe = eff_size(src_width_ff, MAX_W_SZ);
   assign ohe = eff_size(src_height_ff, MAX_H_SZ);

   assign x_lim = (cmd_ff == CMD_SRC_WR) ? owe : dwe;
   assign y_lim = (cmd_ff == CMD_SRC_WR) ? ohe : dhe;
   assign w_sel = (cmd_ff == CMD_SRC_WR) ? ow_e_ff : dw_e_ff;

   assign prod_a = (SIZE_W+Y_W)'(cy_ff) * (SIZE_W+Y_W)'(w_sel);
   assign prod_s = (SIZE_W+Y_W)'(coy_ff) * (SIZE_W+Y_W)'(ow_e_ff);
   assign a_prod = 16'(sq_ff.alpha) * 16'(req_ff.blend_alpha);

   assign last_col = (SIZE_W'(col_ff) + SIZE_W'(1)) == span_w_ff;
   assign last_row = (SIZE_W'(row_ff) + SIZE_W'(1)) == span_h_ff;

   assign stat.is_blit    = (cmd_ff == CMD_BLIT);
   assign stat.span_zero  = (span_w_ff == '0) || (span_h_ff == '0);
   assign stat.last_pixel = last_col && last_row;

   assign req_pix.red   = req_ff.red;
   assign req_pix.green = req_ff.green;
   assign req_pix.blue  = req_ff.blue;
   assign req_pix.alpha = req_ff.pixel_alpha;

   assign blend_pix.red   = div255(sum_r_ff);
   assign blend_pix.green = div255(sum_g_ff);
   assign blend_pix.blue  = div255(sum_b_ff);
   assign blend_pix.alpha = amax_ff;

   // pixel commands run with col at zero, so one address path serves both
   assign dest_addr  = addr_ff + ADDR_W'(col_ff);
   assign src_raddr  = srow_ff + ADDR_W'(col_ff);
   assign dest_we    = (ctl.mem_access && (cmd_ff == CMD_DEST_WR)) || ctl.blit_wr;
   assign dest_re    = (ctl.mem_access && (cmd_ff == CMD_DEST_RD)) || ctl.blit_rd;
   assign src_we     = ctl.mem_access && (cmd_ff == CMD_SRC_WR);
   assign src_re     = ctl.blit_rd;
   assign dest_wdata = ctl.blit_wr ? blend_pix : req_pix;

   always_ff @(posedge clock) begin
      if (dest_we) begin
         dest_mem[dest_addr] <= dest_wdata;
      end
      if (dest_re) begin
         dq_ff <= dest_mem[dest_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[addr_ff] <= req_pix;
      end
      if (src_re) begin
         sq_ff <= src_mem[src_raddr];
      end
   end

   always_comb begin
      dest_width_in  = dest_width_ff;
      dest_height_in = dest_height_ff;
      src_width_in   = src_width_ff;
      src_height_in  = src_height_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_DEST_WIDTH:  dest_width_in  = csr_data;
            CSR_DEST_HEIGHT: dest_height_in = csr_data;
            CSR_SRC_WIDTH:   src_width_in   = csr_data;
            CSR_SRC_HEIGHT:  src_height_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cmd_in      = cmd_ff;
      req_in      = req_ff;
      dw_e_in     = dw_e_ff;
      dh_e_in     = dh_e_ff;
      ow_e_in     = ow_e_ff;
      oh_e_in     = oh_e_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cox_in      = cox_ff;
      coy_in      = coy_ff;
      addr_in     = addr_ff;
      srow_in     = srow_ff;
      span_w_in   = span_w_ff;
      span_h_in   = span_h_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      a_in        = a_ff;
      amax_in     = amax_ff;
      sum_r_in    = sum_r_ff;
      sum_g_in    = sum_g_ff;
      sum_b_in    = sum_b_ff;
      rsp_data_in = rsp_data_ff;
      rsp_read_in = rsp_read_ff;

      if (ctl.latch_req) begin
         cmd_in = req_cmd;
         req_in = req_data;
      end

      if (ctl.clamp) begin
         dw_e_in = dwe;
         dh_e_in = dhe;
         ow_e_in = owe;
         oh_e_in = ohe;
         cx_in   = X_W'(clamp_pos(req_ff.pos_x, x_lim));
         cy_in   = Y_W'(clamp_pos(req_ff.pos_y, y_lim));
         cox_in  = X_W'(clamp_pos(req_ff.src_x, owe));
         coy_in  = Y_W'(clamp_pos(req_ff.src_y, ohe));
         col_in  = '0;
         row_in  = '0;
      end

      if (ctl.addr) begin
         addr_in   = ADDR_W'(prod_a) + ADDR_W'(cx_ff);
         srow_in   = ADDR_W'(prod_s) + ADDR_W'(cox_ff);
         // trim the span to what fits in both images
         span_w_in = min3(req_ff.span_w, dw_e_ff - SIZE_W'(cx_ff),
                          ow_e_ff - SIZE_W'(cox_ff));
         span_h_in = min3(req_ff.span_h, dh_e_ff - SIZE_W'(cy_ff),
                          oh_e_ff - SIZE_W'(coy_ff));
      end

      if (ctl.blit_alpha) begin
         a_in = div255(a_prod);
      end

      if (ctl.blit_mix) begin
         sum_r_in = mix_sum(sq_ff.red, dq_ff.red, a_ff);
         sum_g_in = mix_sum(sq_ff.green, dq_ff.green, a_ff);
         sum_b_in = mix_sum(sq_ff.blue, dq_ff.blue, a_ff);
         amax_in  = (dq_ff.alpha > a_ff) ? dq_ff.alpha : a_ff;
      end

      if (ctl.blit_wr) begin
         if (last_col) begin
            col_in  = '0;
            row_in  = row_ff + Y_W'(1);
            addr_in = addr_ff + ADDR_W'(dw_e_ff);
            srow_in = srow_ff + ADDR_W'(ow_e_ff);
         end else begin
            col_in = col_ff + X_W'(1);
         end
      end

      if (ctl.load_rsp) begin
         rsp_read_in = (cmd_ff == CMD_DEST_RD);
         rsp_data_in = (cmd_ff == CMD_DEST_RD) ? dq_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff  <= CFG_RESET;
         dest_height_ff <= CFG_RESET;
         src_width_ff   <= CFG_RESET;
         src_height_ff  <= CFG_RESET;
      end else begin
         dest_width_ff  <= dest_width_in;
         dest_height_ff <= dest_height_in;
         src_width_ff   <= src_width_in;
         src_height_ff  <= src_height_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      req_ff      <= req_in;
      dw_e_ff     <= dw_e_in;
      dh_e_ff     <= dh_e_in;
      ow_e_ff     <= ow_e_in;
      oh_e_ff     <= oh_e_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cox_ff      <= cox_in;
      coy_ff      <= coy_in;
      addr_ff     <= addr_in;
      srow_ff     <= srow_in;
      span_w_ff   <= span_w_in;
      span_h_ff   <= span_h_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      a_ff        <= a_in;
      amax_ff     <= amax_in;
      sum_r_ff    <= sum_r_in;
      sum_g_ff    <= sum_g_in;
      sum_b_ff    <= sum_b_in;
      rsp_data_ff <= rsp_data_in;
      rsp_read_ff <= rsp_read_in;
   end

   assign rsp_data    = rsp_data_ff;
   assign rsp_is_read = rsp_read_ff;

endmodule

/* hdl/alpha_blend_blit_engine.sv */
// Alpha blend blit engine: keeps a destination and a source store of
// 64 x 64 RGBA pixels and handles one request at a time. Pixel writes, pixel
// reads and zero-size blits pass through accept, clamp, address, memory
// access and result load. A blit adds a loop over its trimmed w x h span:
// each pixel is read from both stores, its alpha scaled, the channels
// blended and the pixel written back through the single write port of the
// destination store. Every request gives one result; writes and blits return
// zero data with tuser low. The result sits in an output register, so the
// next request is taken while it waits. The user must write the size
// registers over the csr channel only while no request is open; the block itself does not enforce this.
// Top level; depends on abbe_pkg, abbe_ctrl and abbe_datapath.

module alpha_blend_blit_engine (
   input  logic                                clock,
   input  logic                                reset,
   // pos_x, pos_y, src_x, src_y, span_w, span_h, blend_alpha,
   // red, green, blue, pixel_alpha, zero pad
   input  logic [abbe_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [abbe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // is_read
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [abbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [abbe_pkg::SIZE_W-1:0]         csr_data
);
   import abbe_pkg::*;

   ctl_type      ctl;
   stat_type     stat;
   req_data_type req_data;
   pixel_type    rsp_data;
   logic         csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_data  = req_tdata;
   assign rsp_tdata = rsp_data;

   abbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   abbe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .stat        (stat),
      .req_cmd     (cmd_type'(req_tuser)),
      .req_data    (req_data),
      .csr_wr      (csr_wr),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_data    (rsp_data),
      .rsp_is_read (rsp_tuser)
   );

endmodule

/* hdl/abbe_check.sv */
// port-level checks for the alpha blend blit engine, bound to the top level
// depends on abbe_pkg and alpha_blend_blit_engine

module abbe_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [abbe_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // one request at a time: no back-to-back request transfers
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one is open");

   // only reads carry pixel data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("non-read result carries data");

endmodule

bind alpha_blend_blit_engine abbe_check u_check (.*);

/* verif/tb_alpha_blend_blit_engine.sv */
// self-checking testbench for the alpha blend blit engine: directed pixel and blit
// cases, then random traffic under several image sizes and handshake pacing modes
// depends on abbe_pkg and alpha_blend_blit_engine from hdl

module tb_alpha_blend_blit_engine;
   import abbe_pkg::*;

   localparam int OPAQUE = 255;
   localparam int ITEMS_PER_SETTING = 155;

   typedef struct packed {
      pixel_type px;
      logic      is_read;
   } pixel_result_type;

   typedef struct {
      int dx;
      int dy;
      int sx;
      int sy;
      int w;
      int h;
   } blit_rect_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [SIZE_W-1:0]      csr_data = '0;

   // shadow copy of both pixel stores and the size registers
   pixel_type   dst_mem [STORE_DEPTH];
   pixel_type   src_mem [STORE_DEPTH];
   bit          dst_written [STORE_DEPTH];
   bit          src_written [STORE_DEPTH];
   logic [SIZE_W-1:0] size_reg [4] = '{CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET};
   pixel_result_type awaited_results [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int err_count = 0;
   int n_sent = 0;
   int n_by_cmd [4] = '{0, 0, 0, 0};
   int n_blit_px = 0;
   int n_settings = 0;

   // raw register values per setting; -1 picks a random small size
   int size_table [12][4] = '{
      '{64, 64, 64, 64}, '{1, 1, 1, 1}, '{8, 8, 8, 8},
      '{0, 0, 0, 0}, '{127, 127, 127, 127}, '{16, 4, 5, 12},
      '{1, 64, 64, 1}, '{12, 10, 7, 16}, '{64, 2, 3, 64},
      '{127, 0, 100, 2}, '{-1, -1, -1, -1}, '{64, 64, 64, 64}
   };

   alpha_blend_blit_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   function automatic int eff_size(csr_index_type i);
      int mx;
      int s;
      mx = (i == CSR_DEST_WIDTH || i == CSR_SRC_WIDTH) ? MAX_WIDTH : MAX_HEIGHT;
      s = size_reg[i];
      if (s < 1) s = 1;
      if (s > mx) s = mx;
      return s;
   endfunction

   function automatic int clamp_coord(logic [POS_W-1:0] v, int n);
      int s;
      s = $signed(v);
      if (s < 0) return 0;
      if (s > n - 1) return n - 1;
      return s;
   endfunction

   function automatic int min_of(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] d, int a);
      return 8'((int'(s) * a + (OPAQUE - a) * int'(d)) / OPAQUE);
   endfunction

   // origins clamped first, then the span trimmed to both images
   function automatic blit_rect_type blit_area(req_data_type d);
      blit_rect_type r;
      int dw, dh, ow, oh;
      dw = eff_size(CSR_DEST_WIDTH);
      dh = eff_size(CSR_DEST_HEIGHT);
      ow = eff_size(CSR_SRC_WIDTH);
      oh = eff_size(CSR_SRC_HEIGHT);
      r.dx = clamp_coord(d.pos_x, dw);
      r.dy = clamp_coord(d.pos_y, dh);
      r.sx = clamp_coord(d.src_x, ow);
      r.sy = clamp_coord(d.src_y, oh);
      r.w = min_of(int'(d.span_w), min_of(dw - r.dx, ow - r.sx));
      r.h = min_of(int'(d.span_h), min_of(dh - r.dy, oh - r.sy));
      return r;
   endfunction

   function automatic pixel_type req_pixel(req_data_type d);
      pixel_type p;
      p.red = d.red;
      p.green = d.green;
      p.blue = d.blue;
      p.alpha = d.pixel_alpha;
      return p;
   endfunction

   function automatic req_data_type random_req();
      req_data_type d;
      d = req_data_type'({$urandom, $urandom, $urandom});
      d.pad = '0;
      return d;
   endfunction

   function automatic req_data_type build_req(int px, int py, int sx, int sy, int sw, int sh,
                                              int ba, int r, int g, int b, int a);
      req_data_type d;
      d = '0;
      d.pos_x = POS_W'(px);
      d.pos_y = POS_W'(py);
      d.src_x = POS_W'(sx);
      d.src_y = POS_W'(sy);
      d.span_w = SIZE_W'(sw);
      d.span_h = SIZE_W'(sh);
      d.blend_alpha = 8'(ba);
      d.red = 8'(r);
      d.green = 8'(g);
      d.blue = 8'(b);
      d.pixel_alpha = 8'(a);
      return d;
   endfunction

   // mostly in range, sometimes just past an edge or anywhere in the field
   function automatic logic [POS_W-1:0] pick_coord(int n);
      case ($urandom_range(7))
         0: return POS_W'($urandom);
         1: return POS_W'(-int'($urandom_range(1, 4)));
         2: return POS_W'(n - 1 + int'($urandom_range(1, 4)));
         default: return POS_W'($urandom_range(n - 1));
      endcase
   endfunction

   // updates the shadow stores for one accepted request and queues its result
   task automatic apply_to_stores(input cmd_type cmd, input req_data_type d);
      pixel_result_type res;
      blit_rect_type r;
      pixel_type s, t, n;
      int dw, dh, ow, oh, idx, di, si, a;
      dw = eff_size(CSR_DEST_WIDTH);
      dh = eff_size(CSR_DEST_HEIGHT);
      ow = eff_size(CSR_SRC_WIDTH);
      oh = eff_size(CSR_SRC_HEIGHT);
      res.px = '0;
      res.is_read = 1'b0;
      case (cmd)
         CMD_DEST_WR, CMD_DEST_RD: begin
            idx = clamp_coord(d.pos_x, dw) + clamp_coord(d.pos_y, dh) * dw;
            if (cmd == CMD_DEST_WR) begin
               dst_mem[idx] = req_pixel(d);
               dst_written[idx] = 1'b1;
            end else begin
               res.px = dst_mem[idx];
               res.is_read = 1'b1;
            end
         end
         CMD_SRC_WR: begin
            idx = clamp_coord(d.pos_x, ow) + clamp_coord(d.pos_y, oh) * ow;
            src_mem[idx] = req_pixel(d);
            src_written[idx] = 1'b1;
         end
         CMD_BLIT: begin
            r = blit_area(d);
            for (int j = 0; j < r.h; j++) begin
               for (int i = 0; i < r.w; i++) begin
                  di = (r.dx + i) + (r.dy + j) * dw;
                  si = (r.sx + i) + (r.sy + j) * ow;
                  t = dst_mem[di];
                  s = src_mem[si];
                  a = int'(s.alpha) * int'(d.blend_alpha) / OPAQUE;
                  n.red = mix_chan(s.red, t.red, a);
                  n.green = mix_chan(s.green, t.green, a);
                  n.blue = mix_chan(s.blue, t.blue, a);
                  n.alpha = (int'(t.alpha) > a) ? t.alpha : 8'(a);
                  dst_mem[di] = n;
                  n_blit_px++;
               end
            end
         end
         default: begin
         end
      endcase
      awaited_results.push_back(res);
   endtask

   // entered and left at a falling edge
   task automatic send_req(input cmd_type cmd, input req_data_type d);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = d;
      req_tuser = cmd;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_to_stores(cmd, d);
      n_sent++;
      n_by_cmd[cmd]++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_pixel(input cmd_type cmd, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y);
      req_data_type d;
      d = random_req();
      d.pos_x = x;
      d.pos_y = y;
      send_req(cmd, d);
   endtask

   task automatic wait_idle();
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_size(input csr_index_type idx, input logic [SIZE_W-1:0] v);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      size_reg[idx] = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_sizes(input int row);
      int v;
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         v = size_table[row][i];
         if (v < 0) v = $urandom_range(1, 16);
         write_size(csr_index_type'(i), SIZE_W'(v));
      end
      n_settings++;
   endtask

   // writes every pixel a blit will read that holds no data yet
   task automatic fill_area(input blit_rect_type r);
      int dw, ow;
      dw = eff_size(CSR_DEST_WIDTH);
      ow = eff_size(CSR_SRC_WIDTH);
      for (int j = 0; j < r.h; j++) begin
         for (int i = 0; i < r.w; i++) begin
            if (!dst_written[(r.dx + i) + (r.dy + j) * dw])
               write_pixel(CMD_DEST_WR, POS_W'(r.dx + i), POS_W'(r.dy + j));
            if (!src_written[(r.sx + i) + (r.sy + j) * ow])
               write_pixel(CMD_SRC_WR, POS_W'(r.sx + i), POS_W'(r.sy + j));
         end
      end
   endtask

   task automatic random_blit(input bit noisy);
      req_data_type d;
      blit_rect_type r;
      int dw, dh, ow, oh;
      dw = eff_size(CSR_DEST_WIDTH);
      dh = eff_size(CSR_DEST_HEIGHT);
      ow = eff_size(CSR_SRC_WIDTH);
      oh = eff_size(CSR_SRC_HEIGHT);
      d = random_req();
      if (!noisy) begin
         d.pos_x = pick_coord(dw);
         d.pos_y = pick_coord(dh);
         d.src_x = pick_coord(ow);
         d.src_y = pick_coord(oh);
      end
      // keep spans short on large images so the pre-fill stays cheap
      if (dw * dh > 256 || ow * oh > 256) begin
         case ($urandom_range(9))
            0: begin
               d.span_w = SIZE_W'($urandom_range(7, 127));
               d.span_h = SIZE_W'($urandom_range(1));
            end
            1: begin
               d.span_w = SIZE_W'($urandom_range(1));
               d.span_h = SIZE_W'($urandom_range(7, 127));
            end
            default: begin
               d.span_w = SIZE_W'($urandom_range(6));
               d.span_h = SIZE_W'($urandom_range(6));
            end
         endcase
      end
      r = blit_area(d);
      fill_area(r);
      send_req(CMD_BLIT, d);
      if (r.w > 0 && r.h > 0 && $urandom_range(1)) begin
         d = random_req();
         d.pos_x = POS_W'(r.dx + int'($urandom_range(r.w - 1)));
         d.pos_y = POS_W'(r.dy + int'($urandom_range(r.h - 1)));
         send_req(CMD_DEST_RD, d);
      end
   endtask

   task automatic random_item();
      req_data_type d;
      int k, x, y, dw, dh;
      dw = eff_size(CSR_DEST_WIDTH);
      dh = eff_size(CSR_DEST_HEIGHT);
      k = $urandom_range(99);
      d = random_req();
      if (k < 30) begin
         d.pos_x = pick_coord(dw);
         d.pos_y = pick_coord(dh);
         send_req(CMD_DEST_WR, d);
      end else if (k < 50) begin
         d.pos_x = pick_coord(eff_size(CSR_SRC_WIDTH));
         d.pos_y = pick_coord(eff_size(CSR_SRC_HEIGHT));
         send_req(CMD_SRC_WR, d);
      end else if (k < 68) begin
         d.pos_x = pick_coord(dw);
         d.pos_y = pick_coord(dh);
         x = clamp_coord(d.pos_x, dw);
         y = clamp_coord(d.pos_y, dh);
         if (!dst_written[x + y * dw]) write_pixel(CMD_DEST_WR, POS_W'(x), POS_W'(y));
         send_req(CMD_DEST_RD, d);
      end else begin
         random_blit(k >= 95);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (awaited_results.size() == 0) begin
            $error("result transfer with no result outstanding");
            err_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("out_red", want.px.red, got.red);
            check_field("out_green", want.px.green, got.green);
            check_field("out_blue", want.px.blue, got.blue);
            check_field("out_alpha", want.px.alpha, got.alpha);
            check_field("is_read", 8'(want.is_read), 8'(rsp_tuser));
         end
      end
   end

   // writes and reads at corners and beside the origin, with coordinates far outside the image
   task automatic test_pixel_access();
      send_req(CMD_DEST_WR, build_req(0, 0, 0, 0, 0, 0, 0, 255, 0, 255, 0));
      send_req(CMD_DEST_WR, build_req(255, 255, -256, -256, 127, 127, 255, 0, 255, 0, 255));
      send_req(CMD_SRC_WR, build_req(-256, -256, 0, 0, 0, 0, 0, 255, 255, 255, 255));
      send_req(CMD_SRC_WR, build_req(1, 0, 0, 0, 0, 0, 0, 'h12, 'h34, 'h56, 'h80));
      send_req(CMD_DEST_WR, build_req(1, 0, 0, 0, 0, 0, 0, 'haa, 'h55, 'haa, 'h55));
      send_req(CMD_DEST_RD, build_req(-1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_req(CMD_DEST_RD, build_req(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // zero spans, full and zero opacity, half alpha, span trimmed at the far corner
   task automatic test_blit_corners();
      send_req(CMD_BLIT, build_req(0, 0, 0, 0, 0, 5, 255, 0, 0, 0, 0));
      send_req(CMD_BLIT, build_req(0, 0, 0, 0, 2, 0, 255, 0, 0, 0, 0));
      send_req(CMD_BLIT, build_req(0, 0, 0, 0, 2, 1, 255, 0, 0, 0, 0));
      send_req(CMD_DEST_RD, build_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_req(CMD_DEST_RD, build_req(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_req(CMD_BLIT, build_req(1, 0, 1, 0, 1, 1, 0, 0, 0, 0, 0));
      send_req(CMD_DEST_RD, build_req(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_req(CMD_BLIT, build_req(255, 255, -256, -256, 127, 127, 200, 0, 0, 0, 0));
      send_req(CMD_DEST_RD, build_req(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_req(CMD_BLIT, build_req(0, 0, 1, 0, 1, 1, 128, 0, 0, 0, 0));
      send_req(CMD_DEST_RD, build_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // three size settings per pacing mode, one full drain halfway through each
   task automatic test_random_traffic(input int send_gap, input int rsp_gap, input int row);
      int target, pause_at;
      bit paused;
      idle_pct = send_gap;
      stall_pct = rsp_gap;
      for (int s = row; s < row + 3; s++) begin
         set_sizes(s);
         target = n_sent + ITEMS_PER_SETTING;
         pause_at = n_sent + ITEMS_PER_SETTING / 2;
         paused = 1'b0;
         while (n_sent < target) begin
            random_item();
            if (!paused && n_sent >= pause_at) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_pixel_access();
      test_blit_corners();
      test_random_traffic(0, 0, 0);
      test_random_traffic(66, 0, 3);
      test_random_traffic(0, 66, 6);
      test_random_traffic(29, 29, 9);
      waited = 0;
      while (awaited_results.size() != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d results never arrived", awaited_results.size());
         err_count++;
      end
      $display("covered %0d requests: %0d destination writes, %0d source writes, %0d reads,",
               n_sent, n_by_cmd[CMD_DEST_WR], n_by_cmd[CMD_SRC_WR], n_by_cmd[CMD_DEST_RD]);
      $display("%0d blits blending %0d pixels, over %0d size settings and four pacing modes",
               n_by_cmd[CMD_BLIT], n_blit_px, n_settings);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
